[rtl/mera_pkg.sv]
// ============================================================================
// mera_pkg
// Shared widths and constants of the maximal empty rectangle block.
// ============================================================================
`timescale 1ns / 1ps

package mera_pkg;

    localparam int SIZE_W = 7;
    localparam int AREA_W = 13;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
    localparam logic [AREA_W-1:0] AREA_MAX   = '1;

endpackage

[rtl/mera_best.sv]
// ============================================================================
// mera_best
// Registered area product, saturation and running maximum.
// ============================================================================
`timescale 1ns / 1ps

module mera_best #(
    parameter int NW = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         valid,
    input  logic [NW-1:0]                height,
    input  logic [NW-1:0]                width,
    output logic [mera_pkg::AREA_W-1:0]  best,
    output logic [mera_pkg::AREA_W-1:0]  best_next
);
    import mera_pkg::*;

    localparam int PW = (2 * NW > AREA_W) ? 2 * NW : AREA_W + 1;

    logic [PW-1:0]     prod_reg;
    logic              pv_reg;
    logic              pv_next;
    logic [AREA_W-1:0] best_reg;
    logic [AREA_W-1:0] sat;

    always_comb
    begin
        sat = (prod_reg > PW'(AREA_MAX)) ? AREA_MAX : prod_reg[AREA_W-1:0];
        pv_next = valid && !clear;
        if (clear)
        begin
            best_next = '0;
        end
        else if (pv_reg && (sat > best_reg))
        begin
            best_next = sat;
        end
        else
        begin
            best_next = best_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(height) * PW'(width);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            pv_reg   <= pv_next;
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

[rtl/max_empty_rectangle_area.sv]
// ============================================================================
// max_empty_rectangle_area
// Largest all-free rectangle of a square binary matrix fed in row-major order.
// Each cell passes through accept, height read-modify-write and stack scan,
// where taller entries are popped before the cell is pushed; a row end then
// flushes the remaining entries. A new cell is taken only once the last one
// is done. After the last flush the result stage loads the registered result
// beat.
// Reset clears control state at once; there is no memory clearing pass.
// ============================================================================
`timescale 1ns / 1ps

module max_empty_rectangle_area #(
    parameter int MAX_N = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mera_pkg::SIZE_W-1:0] cfg_wr_data,   // matrix_size
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [0] blocked
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata   // [12:0] max_area
);
    import mera_pkg::*;

    localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NW = $clog2(MAX_N + 1);

    typedef struct packed {
        logic [CW-1:0] idx;
        logic [CW-1:0] left;
        logic [NW-1:0] h;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SCAN,
        S_FLUSH,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    entry_t            top_reg, top_next;
    logic [CW-1:0]     cur_c_reg, cur_c_next;
    logic [NW-1:0]     cur_h_reg, cur_h_next;
    logic              blk_reg, blk_next;
    logic              row0_reg, row0_next;
    logic              out_valid_reg, out_valid_next;
    logic [AREA_W-1:0] out_data_reg, out_data_next;

    logic [NW-1:0]     hmem [MAX_N];
    logic [NW-1:0]     hmem_q;
    logic              h_we;
    logic [NW-1:0]     h_new;

    entry_t            smem [MAX_N];
    entry_t            s_rd_reg;
    entry_t            s_wd_reg;
    logic              s_fwd_reg;
    logic              s_we;
    logic [CW-1:0]     s_wa;
    logic [CW-1:0]     s_ra;
    logic [NW-1:0]     cnt_m1;
    logic [NW-1:0]     cnt_m2;
    entry_t            below;

    logic [31:0]       n_wide;
    logic [NW-1:0]     n;
    logic [NW-1:0]     n_m1;
    logic [CW-1:0]     c_eff;
    logic [CW-1:0]     row_eff;
    logic [NW-1:0]     pop_pos;
    logic              pop_valid;
    logic [NW-1:0]     pop_w;
    logic              clear_best;
    logic [AREA_W-1:0] best;
    logic [AREA_W-1:0] best_next;

    always_comb
    begin
        n_wide = 32'(size_reg);
        if (n_wide == 32'd0)
        begin
            n_wide = 32'd1;
        end
        if (n_wide > 32'(MAX_N))
        begin
            n_wide = 32'(MAX_N);
        end
        n    = n_wide[NW-1:0];
        n_m1 = n - 1'b1;
        c_eff   = (NW'(col_reg) >= n) ? n_m1[CW-1:0] : col_reg;
        row_eff = (NW'(row_reg) >= n) ? '0 : row_reg;
    end

    assign below   = s_fwd_reg ? s_wd_reg : s_rd_reg;
    assign pop_pos = (state_reg == S_FLUSH) ? n : NW'(cur_c_reg);
    assign cnt_m1  = cnt_reg - 1'b1;
    assign s_wa    = cnt_m1[CW-1:0];

    always_comb
    begin
        if (blk_reg)
        begin
            h_new = '0;
        end
        else if (row0_reg)
        begin
            h_new = NW'(1);
        end
        else if (hmem_q < NW'(MAX_N))
        begin
            h_new = hmem_q + 1'b1;
        end
        else
        begin
            h_new = hmem_q;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        cur_c_next     = cur_c_reg;
        cur_h_next     = cur_h_reg;
        blk_next       = blk_reg;
        row0_next      = row0_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        h_we           = 1'b0;
        s_we           = 1'b0;
        pop_valid      = 1'b0;
        pop_w          = pop_pos - NW'(top_reg.left);
        clear_best     = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cur_c_next = c_eff;
                    row_next   = row_eff;
                    blk_next   = s_axis_tdata[0];
                    row0_next  = (row_eff == '0);
                    if ((row_eff == '0) && (c_eff == '0))
                    begin
                        cnt_next   = '0;
                        clear_best = 1'b1;
                    end
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                h_we       = 1'b1;
                cur_h_next = h_new;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if ((cnt_reg != '0) && (top_reg.h > cur_h_reg))
                begin
                    pop_valid = 1'b1;
                    top_next  = below;
                    cnt_next  = cnt_m1;
                end
                else
                begin
                    s_we         = (cnt_reg != '0);
                    top_next.idx = cur_c_reg;
                    top_next.left = (cnt_reg == '0) ? '0 : top_reg.idx + 1'b1;
                    top_next.h   = cur_h_reg;
                    cnt_next     = cnt_reg + 1'b1;
                    if ((NW'(cur_c_reg) + 1'b1) < n)
                    begin
                        col_next   = cur_c_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        col_next   = '0;
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (cnt_reg != '0)
                begin
                    pop_valid = 1'b1;
                    top_next  = below;
                    cnt_next  = cnt_m1;
                end
                else if ((NW'(row_reg) + 1'b1) < n)
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = best_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            size_next = cfg_wr_data;
            row_next  = '0;
            col_next  = '0;
            cnt_next  = '0;
        end
    end

    assign cnt_m2 = cnt_next - NW'(2);
    assign s_ra   = cnt_m2[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hmem[cur_c_reg] <= h_new;
        end
        hmem_q <= hmem[c_eff];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[s_wa] <= top_reg;
        end
        s_rd_reg <= smem[s_ra];
        s_wd_reg <= top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            s_fwd_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            s_fwd_reg     <= s_we && (s_wa == s_ra);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        cur_c_reg    <= cur_c_next;
        cur_h_reg    <= cur_h_next;
        blk_reg      <= blk_next;
        row0_reg     <= row0_next;
        out_data_reg <= out_data_next;
    end

    mera_best #(
        .NW (NW)
    ) u_best (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear_best),
        .valid     (pop_valid),
        .height    (top_reg.h),
        .width     (pop_w),
        .best      (best),
        .best_next (best_next)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - AREA_W){1'b0}}, out_data_reg};

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(MAX_N))
        else $error("stack count beyond depth");

    a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (cnt_reg == '0))
        else $error("result stage with stack entries left");

    a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_UPD))
        else $error("accepted beat did not start height update");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_FIN))
        else $error("result beat raised outside result stage");

    a_fin_best_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && $past(state_reg == S_FIN)) |-> (best_next == best))
        else $error("best area moving while result waits");

endmodule

[dv/tb_top.sv]
// ============================================================================
// tb_top
// Checks the maximal empty rectangle block against its own predictor.
// Matrices of many sizes are streamed in cell by cell with random gaps on
// both sides; each area beat is compared with the predicted area.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    import mera_pkg::*;

    localparam int MAX_N         = 64;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int HOLD_CYCLES   = 400;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;   // [0] blocked
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;         // [12:0] max_area

    max_empty_rectangle_area #(
        .MAX_N(MAX_N)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Predictor state
    logic [SIZE_W-1:0] size_reg;
    logic [6:0]        hist_height [MAX_N];
    logic [5:0]        col_stack   [MAX_N];
    int                stack_depth;
    int                cur_row;
    int                cur_col;
    logic [AREA_W-1:0] best_so_far;

    logic [AREA_W-1:0] expected_area [$];
    logic [AREA_W-1:0] want_area;

    int  cycle_count       = 0;
    int  cells_sent        = 0;
    int  areas_predicted   = 0;
    int  areas_checked     = 0;
    int  area_errors       = 0;
    int  sizes_written     = 0;
    int  largest_side      = 0;
    bit  send_idle         = 1'b0;
    bit  recv_idle         = 1'b0;
    int  hold_len          = 0;
    int  hold_seq          = 0;
    int  hold_seen         = 0;
    int  hold_left         = 0;
    int  ready_gap         = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d areas still pending",
                     cycle_count, expected_area.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int pick_density();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 10;
            2: return 30;
            3: return 50;
            4: return 80;
            default: return 100;
        endcase
    endfunction

    function automatic int side_len();
        int n;
        n = size_reg;
        if (n == 0)
            n = 1;
        if (n > MAX_N)
            n = MAX_N;
        return n;
    endfunction

    // Receiver: long hold on request, else random stalls when enabled
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen     <= hold_seq;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (ready_gap > 0)
        begin
            ready_gap     <= ready_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (recv_idle && $urandom_range(0, 3) == 0)
        begin
            ready_gap     <= pick_gap();
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string what, input int want, input int got);
        area_errors++;
        if (area_errors <= 10)
            $display("Mismatch at cycle %0d: %s, expected %0d, actual %0d",
                     cycle_count, what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_area.size() == 0)
            begin
                note_mismatch("area beat with nothing pending", -1, m_axis_tdata[AREA_W-1:0]);
            end
            else
            begin
                want_area = expected_area.pop_front();
                areas_checked++;
                if (m_axis_tdata[AREA_W-1:0] !== want_area)
                    note_mismatch("max_area", want_area, m_axis_tdata[AREA_W-1:0]);
            end
        end
    end

    task automatic pop_column(input int pos);
        int h;
        int left;
        int area;
        stack_depth--;
        h = hist_height[col_stack[stack_depth]];
        if (stack_depth != 0)
            left = int'(col_stack[stack_depth - 1]) + 1;
        else
            left = 0;
        area = h * (pos - left);
        if (area > AREA_MAX)
            area = AREA_MAX;
        if (area > best_so_far)
            best_so_far = AREA_W'(area);
    endtask

    task automatic predict_cell(input logic blk);
        int n;
        int c;
        int h;
        n = side_len();
        c = cur_col;
        if (c >= n)
            c = n - 1;
        if (cur_row >= n)
            cur_row = 0;
        if (cur_row == 0 && c == 0)
        begin
            for (int i = 0; i < MAX_N; i++)
                hist_height[i] = '0;
            stack_depth = 0;
            best_so_far = '0;
        end
        if (blk)
            hist_height[c] = '0;
        else if (hist_height[c] < MAX_N)
            hist_height[c] = hist_height[c] + 7'd1;
        h = hist_height[c];
        while (stack_depth != 0 && hist_height[col_stack[stack_depth - 1]] > h)
            pop_column(c);
        if (stack_depth < MAX_N)
        begin
            col_stack[stack_depth] = 6'(c);
            stack_depth++;
        end
        if (c + 1 < n)
        begin
            cur_col = c + 1;
            return;
        end
        while (stack_depth != 0)
            pop_column(n);
        cur_col = 0;
        if (cur_row + 1 < n)
        begin
            cur_row++;
            return;
        end
        cur_row = 0;
        expected_area.push_back(best_so_far);
        areas_predicted++;
    endtask

    task automatic send_cell(input logic blk);
        int gap;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, blk};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        cells_sent++;
        predict_cell(blk);
    endtask

    task automatic send_random_cells(input int pct_blocked, input int count);
        for (int i = 0; i < count; i++)
            send_cell($urandom_range(0, 99) < pct_blocked);
    endtask

    task automatic send_pattern(input logic [63:0] bits, input int count);
        for (int i = 0; i < count; i++)
            send_cell(bits[i]);
    endtask

    // Drain pending areas and in-flight cells, then write matrix_size
    task automatic write_size(input int value);
        s_axis_tvalid <= 1'b0;
        while (expected_area.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[SIZE_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        size_reg    = value[SIZE_W-1:0];
        cur_row     = 0;
        cur_col     = 0;
        stack_depth = 0;
        sizes_written++;
        if (side_len() > largest_side)
            largest_side = side_len();
    endtask

    task automatic test_default_size();
        send_idle = 1'b1;
        recv_idle <= 1'b1;
        largest_side = side_len();
        send_random_cells(30, side_len() * side_len());
    endtask

    task automatic test_single_cell();
        write_size(1);
        send_pattern(64'b10, 2);
        write_size(0);
        send_pattern(64'b0, 1);
    endtask

    task automatic test_small_patterns();
        write_size(2);
        send_pattern(64'b0000, 4);
        // rows: 0 1 0 / 0 0 0 / 1 0 0, lowest bit first
        write_size(3);
        send_pattern(64'b001_000_010, 9);
    endtask

    task automatic test_size_rewrite();
        write_size(3);
        send_pattern(64'b01, 2);
        write_size(2);
        send_pattern(64'b0001, 4);
    endtask

    task automatic test_backpressure();
        write_size(1);
        send_idle = 1'b0;
        recv_idle <= 1'b0;
        hold_len  <= HOLD_CYCLES;
        hold_seq  <= hold_seq + 1;
        send_random_cells(50, 40);
    endtask

    task automatic test_largest_size();
        send_idle = 1'b1;
        recv_idle <= 1'b1;
        write_size(127);
        send_random_cells(20, 2 * MAX_N + 5);
    endtask

    task automatic test_random_matrices();
        int start_cells;
        int n;
        int side;
        int r;
        start_cells = cells_sent;
        while (cells_sent - start_cells < 750)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                n = 0;
            else if (r < 70)
                n = $urandom_range(1, 6);
            else if (r < 95)
                n = $urandom_range(7, 12);
            else
                n = $urandom_range(13, 20);
            write_size(n);
            side = side_len();
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle <= ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3))
                send_random_cells(pick_density(), side * side);
            // break off a matrix now and then; the next size write restarts it
            if (side > 1 && $urandom_range(0, 9) == 0)
                send_random_cells(pick_density(), $urandom_range(1, side * side - 1));
        end
    endtask

    initial
    begin
        size_reg    = SIZE_RESET;
        stack_depth = 0;
        cur_row     = 0;
        cur_col     = 0;
        best_so_far = '0;
        for (int i = 0; i < MAX_N; i++)
        begin
            hist_height[i] = '0;
            col_stack[i]   = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size();
        test_single_cell();
        test_small_patterns();
        test_size_rewrite();
        test_backpressure();
        test_random_matrices();
        test_largest_size();

        s_axis_tvalid <= 1'b0;
        while (expected_area.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Streamed %0d cells over %0d size settings (largest side %0d).",
                 cells_sent, sizes_written, largest_side);
        $display("Compared %0d area beats of %0d predicted; %0d mismatches.",
                 areas_checked, areas_predicted, area_errors);
        if (area_errors == 0 && expected_area.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/mera_pkg.sv
rtl/mera_best.sv
rtl/max_empty_rectangle_area.sv
dv/tb_top.sv
